// File: rtl/euler_to_quaternion_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the euler_to_quaternion block
// Shared helpers for concurrent checks
// ---------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH
// assert that a implies b at the same edge
`define E2Q_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// assert that a implies b at the next edge
`define E2Q_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// File: rtl/e2q_pkg.sv
// ---------------------------------------------------------------------------
// e2q_pkg
// Types and constants of the Euler angle to quaternion converter
// ---------------------------------------------------------------------------
package e2q_pkg;
    localparam int ANG_W    = 17;
    localparam int CSTEPS   = 16;
    localparam int CX_W     = 33;
    localparam int CZ_W     = 26;
    localparam int TRIG_W   = 22;
    localparam int TRIG_Q   = 20;
    localparam int QDEPTH   = 4;
    localparam logic signed [CX_W-1:0] CORDIC_ONE = 33'sd652032874;

    typedef struct packed {
        logic signed [CZ_W-1:0] z;
        logic                   neg_cos;
    } folded_t;

    function automatic logic signed [CZ_W-1:0] atan_c(input int i);
        logic signed [CZ_W-1:0] r;
        case (i)
            0: r = 26'sd2949120;  1: r = 26'sd1740967;  2: r = 26'sd919879;
            3: r = 26'sd466945;   4: r = 26'sd234379;   5: r = 26'sd117304;
            6: r = 26'sd58666;    7: r = 26'sd29335;    8: r = 26'sd14668;
            9: r = 26'sd7334;     10: r = 26'sd3667;    11: r = 26'sd1833;
            12: r = 26'sd917;     13: r = 26'sd458;     14: r = 26'sd229;
            default: r = 26'sd115;
        endcase
        return r;
    endfunction

    // wrap to [-180,180) and fold into [-90,90]
    function automatic folded_t fold(input logic signed [ANG_W-1:0] a_in);
        folded_t f;
        logic signed [ANG_W+1:0] a;
        a = 19'(a_in);
        f.neg_cos = 1'b0;
        if (a >= 19'sd46080)
            a = a - 19'sd92160;
        else if (a < -19'sd46080)
            a = a + 19'sd92160;
        if (a > 19'sd23040) begin
            a = 19'sd46080 - a;
            f.neg_cos = 1'b1;
        end else if (a < -19'sd23040) begin
            a = -19'sd46080 - a;
            f.neg_cos = 1'b1;
        end
        f.z = CZ_W'({a, 8'd0});
        return f;
    endfunction
endpackage

// File: rtl/e2q_front.sv
// ---------------------------------------------------------------------------
// e2q_front
// Folds angles and runs pipelined CORDIC, one stage per iteration
// ---------------------------------------------------------------------------
module e2q_front (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic [3*e2q_pkg::ANG_W-1:0] in_ang,
    input  logic adv,
    output logic out_valid,
    output logic [6*e2q_pkg::TRIG_W-1:0] out_trig
);
    localparam int N  = e2q_pkg::CSTEPS;
    localparam int XW = e2q_pkg::CX_W;
    localparam int ZW = e2q_pkg::CZ_W;
    localparam int TW = e2q_pkg::TRIG_W;

    logic signed [XW-1:0] x_reg [0:N][0:2];
    logic signed [XW-1:0] y_reg [0:N][0:2];
    logic signed [ZW-1:0] z_reg [0:N][0:2];
    logic                 n_reg [0:N][0:2];
    logic [N:0]           v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[N-1:0], in_valid};
    end

    // advance the whole pipe together
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e2q_pkg::folded_t f;
                f = e2q_pkg::fold(in_ang[k*e2q_pkg::ANG_W +: e2q_pkg::ANG_W]);
                x_reg[0][k] <= e2q_pkg::CORDIC_ONE;
                y_reg[0][k] <= '0;
                z_reg[0][k] <= f.z;
                n_reg[0][k] <= f.neg_cos;
                for (int i = 0; i < N; i++)
                begin
                    if (!z_reg[i][k][ZW-1])
                    begin
                        x_reg[i+1][k] <= x_reg[i][k] - (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] + (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] - e2q_pkg::atan_c(i);
                    end
                    else
                    begin
                        x_reg[i+1][k] <= x_reg[i][k] + (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] - (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] + e2q_pkg::atan_c(i);
                    end
                    n_reg[i+1][k] <= n_reg[i][k];
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [XW-1:0] c;
            logic signed [XW-1:0] s;
            c = (x_reg[N][k] + XW'(512)) >>> 10;
            s = (y_reg[N][k] + XW'(512)) >>> 10;
            if (n_reg[N][k])
                c = -c;
            out_trig[(2*k)*TW +: TW]   = TW'(s);
            out_trig[(2*k+1)*TW +: TW] = TW'(c);
        end
    end
    assign out_valid = v_reg[N];
endmodule

// File: rtl/e2q_fifo.sv
// ---------------------------------------------------------------------------
// e2q_fifo
// Short queue between front and back
// ---------------------------------------------------------------------------
module e2q_fifo #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  logic [W-1:0] wdata,
    input  logic rd,
    output logic [W-1:0] rdata,
    output logic empty,
    output logic [$clog2(D+1)-1:0] count
);
    localparam int AW = $clog2(D);
    logic [W-1:0] mem_reg [0:D-1];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [$clog2(D+1)-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(D-1)) ? '0 : wp_reg + 1'b1;
            if (rd)
                rp_reg <= (rp_reg == AW'(D-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
        end
    end
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end
    assign rdata = mem_reg[rp_reg];
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;
endmodule

// File: rtl/e2q_back.sv
// ---------------------------------------------------------------------------
// e2q_back
// Products, sums, rounding and saturation, in pipeline stages
// ---------------------------------------------------------------------------
module e2q_back #(
    parameter int OUT_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic [6*e2q_pkg::TRIG_W-1:0] in_trig,
    input  logic adv,
    output logic out_valid,
    output logic [4*OUT_WIDTH-1:0] out_q
);
    localparam int TW = e2q_pkg::TRIG_W;
    localparam int PW = 2*TW;
    localparam int SH = 3*e2q_pkg::TRIG_Q - (OUT_WIDTH-1);
    localparam int FW = 3*TW+1;

    logic signed [TW-1:0] sh, ch, sp, cp, sb, cb;
    assign sh = in_trig[0*TW +: TW];
    assign ch = in_trig[1*TW +: TW];
    assign sp = in_trig[2*TW +: TW];
    assign cp = in_trig[3*TW +: TW];
    assign sb = in_trig[4*TW +: TW];
    assign cb = in_trig[5*TW +: TW];

    logic signed [PW-1:0] pcc_reg, psc_reg, pcs_reg, pss_reg;
    logic signed [TW-1:0] sb1_reg, cb1_reg;
    logic signed [FW-1:0] t_reg [0:7];
    logic signed [FW-1:0] s_reg [0:3];
    logic signed [OUT_WIDTH-1:0] q_reg [0:3];
    logic [3:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pcc_reg <= cp * ch;
            psc_reg <= sp * ch;
            pcs_reg <= cp * sh;
            pss_reg <= sp * sh;
            sb1_reg <= sb;
            cb1_reg <= cb;
            t_reg[0] <= FW'(pcc_reg * cb1_reg);
            t_reg[1] <= FW'(pss_reg * sb1_reg);
            t_reg[2] <= FW'(psc_reg * cb1_reg);
            t_reg[3] <= FW'(pcs_reg * sb1_reg);
            t_reg[4] <= FW'(pcs_reg * cb1_reg);
            t_reg[5] <= FW'(psc_reg * sb1_reg);
            t_reg[6] <= FW'(pcc_reg * sb1_reg);
            t_reg[7] <= FW'(pss_reg * cb1_reg);
            s_reg[0] <= t_reg[0] + t_reg[1] + (FW'(1) <<< (SH-1));
            s_reg[1] <= t_reg[2] + t_reg[3] + (FW'(1) <<< (SH-1));
            s_reg[2] <= t_reg[4] - t_reg[5] + (FW'(1) <<< (SH-1));
            s_reg[3] <= t_reg[6] - t_reg[7] + (FW'(1) <<< (SH-1));
            for (int k = 0; k < 4; k++)
            begin
                logic signed [FW-1:0] r;
                r = s_reg[k] >>> SH;
                if (r > FW'((64'sd1 <<< (OUT_WIDTH-1)) - 1))
                    q_reg[k] <= {1'b0, {(OUT_WIDTH-1){1'b1}}};
                else if (r < -(FW'(64'sd1 <<< (OUT_WIDTH-1))))
                    q_reg[k] <= {1'b1, {(OUT_WIDTH-1){1'b0}}};
                else
                    q_reg[k] <= OUT_WIDTH'(r);
            end
        end
    end
    assign out_valid = v_reg[3];
    assign out_q = {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
endmodule

// File: rtl/euler_to_quaternion.sv
// Path from the accepting edge to the result: 17 register stages of CORDIC
// front (angle fold plus 16 iterations), one queue write, 4 back stages.
// Throughput: one item per cycle; the 17-stage CORDIC pipe and the 4-stage
// product pipe each take one item per clock when not stalled.
// Reset: rst_n clears all valid bits and the queue pointers; data is unreset.
// ---------------------------------------------------------------------------
// euler_to_quaternion
// Converts heading, pitch and bank (Y, X, Z) to a Q1.15 quaternion
// ---------------------------------------------------------------------------
`include "euler_to_quaternion_defines.svh"
module euler_to_quaternion #(
    parameter int OUT_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // heading[16:0], pitch[33:17], bank[50:34]
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [4*OUT_WIDTH-1:0] m_axis_tdata  // quat_w, quat_x, quat_y, quat_z
);
    localparam int TW  = e2q_pkg::TRIG_W;
    localparam int FIX = 17;
    localparam int QD  = e2q_pkg::QDEPTH + FIX + 1;
    localparam int CW  = $clog2(QD+1);

    logic f_valid, f_adv, q_empty, q_rd, b_adv, b_valid;
    logic [6*TW-1:0] f_trig, q_trig;
    logic [CW-1:0] q_cnt;
    logic [CW:0] pend;

    // hold the front whenever the queue could not absorb everything in flight
    assign pend = (CW+1)'(q_cnt) + (CW+1)'(FIX);
    assign f_adv = (pend < (CW+1)'(QD));
    assign s_axis_tready = f_adv;

    e2q_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid && s_axis_tready),
        .in_ang(s_axis_tdata[50:0]),
        .adv(f_adv),
        .out_valid(f_valid),
        .out_trig(f_trig)
    );

    e2q_fifo #(.W(6*TW), .D(QD)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr(f_valid && f_adv), .wdata(f_trig),
        .rd(q_rd), .rdata(q_trig),
        .empty(q_empty), .count(q_cnt)
    );

    // advance the back end unless its output is stalled
    assign b_adv = !b_valid || m_axis_tready;
    assign q_rd  = b_adv && !q_empty;

    e2q_back #(.OUT_WIDTH(OUT_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_rd), .in_trig(q_trig),
        .adv(b_adv),
        .out_valid(b_valid),
        .out_q(m_axis_tdata)
    );
    assign m_axis_tvalid = b_valid;

    `E2Q_ASSERT_IMP(a_no_overflow, f_valid && f_adv, q_cnt < CW'(QD))
    `E2Q_ASSERT_NEXT(a_hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `E2Q_ASSERT_IMP(a_rd_nonempty, q_rd, !q_empty)
endmodule

// File: tb/euler_to_quaternion_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_to_quaternion_checker
// Watches both streams, predicts each quaternion from the accepted angles and
// compares it with the item that leaves the block.
// ---------------------------------------------------------------------------
module euler_to_quaternion_checker #(
    parameter int OUT_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [55:0]            in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [4*OUT_WIDTH-1:0] out_data,
    output int                     errors,
    output int                     pending
);
    typedef logic [4*OUT_WIDTH-1:0] quat_t;

    quat_t quat_fifo[$];

    localparam longint ATAN_TBL[16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // sine and cosine (Q20) of half the raw angle
    function automatic void half_angle_trig(input logic signed [16:0] raw,
                                            output longint sn, output longint cs);
        longint a, x, y, z, nx;
        bit     flip;
        a = raw;
        flip = 0;
        x = 652032874;
        y = 0;
        if (a >= 46080) a -= 92160;
        else if (a < -46080) a += 92160;
        if (a > 23040) begin a = 46080 - a; flip = 1; end
        else if (a < -23040) begin a = -46080 - a; flip = 1; end
        z = a * 256;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z -= ATAN_TBL[i];
            end else begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z += ATAN_TBL[i];
            end
            x = nx;
        end
        cs = floor_shift(x + 512, 10);
        sn = floor_shift(y + 512, 10);
        if (flip) cs = -cs;
    endfunction

    function automatic logic [OUT_WIDTH-1:0] round_sat(longint v);
        int     sh;
        longint mx, r;
        sh = 60 - (OUT_WIDTH - 1);
        mx = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
        r  = floor_shift(v + (longint'(1) <<< (sh - 1)), sh);
        if (r > mx) r = mx;
        if (r < -mx - 1) r = -mx - 1;
        return r[OUT_WIDTH-1:0];
    endfunction

    function automatic quat_t angles_to_quat(logic [55:0] d);
        longint sh, ch, sp, cp, sb, cb;
        quat_t  q;
        half_angle_trig(d[16:0], sh, ch);
        half_angle_trig(d[33:17], sp, cp);
        half_angle_trig(d[50:34], sb, cb);
        q[0*OUT_WIDTH +: OUT_WIDTH] = round_sat(cp*ch*cb + sp*sh*sb);
        q[1*OUT_WIDTH +: OUT_WIDTH] = round_sat(sp*ch*cb + cp*sh*sb);
        q[2*OUT_WIDTH +: OUT_WIDTH] = round_sat(cp*sh*cb - sp*ch*sb);
        q[3*OUT_WIDTH +: OUT_WIDTH] = round_sat(cp*ch*sb - sp*sh*cb);
        return q;
    endfunction

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    initial errors = 0;
    assign pending = quat_fifo.size();

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                quat_fifo.push_back(angles_to_quat(in_data));
            if (out_valid && out_ready) begin
                if (quat_fifo.size() == 0)
                    report("quaternion item with none expected");
                else begin
                    quat_t q;
                    q = quat_fifo.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (out_data[k*OUT_WIDTH +: OUT_WIDTH] != q[k*OUT_WIDTH +: OUT_WIDTH])
                            report($sformatf("component %0d got %h want %h", k,
                                out_data[k*OUT_WIDTH +: OUT_WIDTH],
                                q[k*OUT_WIDTH +: OUT_WIDTH]));
                end
            end
        end
    end
endmodule

// File: tb/euler_to_quaternion_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// euler_to_quaternion_test
// Drives angle sets into the converter under several idling phases and a
// long output hold-off; the checker predicts and compares every quaternion.
// ---------------------------------------------------------------------------
module euler_to_quaternion_test;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;  // heading[16:0], pitch[33:17], bank[50:34]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;       // quat_w, quat_x, quat_y, quat_z
    int          errors, pending;

    int  in_idle_pct = 0;   // sender gap chance, percent
    int  out_idle_pct = 0;  // receiver stall chance, percent
    int  hold_off = 0;      // cycles left in a forced receiver stall

    always #4 clk = ~clk;

    euler_to_quaternion DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    euler_to_quaternion_checker #(.OUT_WIDTH(16)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
        .errors(errors), .pending(pending)
    );

    // receiver: random stalls, plus a counted hold-off when requested
    always @(posedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else
            m_axis_tready <= rst_n && ($urandom_range(99) >= out_idle_pct);
    end

    // random angle: mostly legal range, sometimes any 17-bit pattern
    function automatic logic [16:0] rand_angle();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 17'($urandom);
        if (r == 1) return 17'($signed($urandom_range(6)) - 3 + 46080 * ($urandom_range(2) - 1));
        return 17'(int'($urandom_range(92160)) - 46080);
    endfunction

    // offer one angle set, hold it until accepted; valid drops only in a gap
    task automatic send_angles(input logic [16:0] h, input logic [16:0] p,
                               input logic [16:0] b);
        while ($urandom_range(99) < in_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, b, p, h};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle());
    endtask

    localparam logic [16:0] EDGE_ANG[12] = '{
        17'sd0, 17'sd46080, -17'sd46080, 17'sd23040, -17'sd23040, 17'sd23041,
        -17'sd23041, 17'sd65535, 17'h10000, 17'sd11520, 17'sd1, -17'sd1
    };

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, fold edges and wrap-around
        for (int i = 0; i < 12; i++)
            send_angles(EDGE_ANG[i], EDGE_ANG[(i + 3) % 12], EDGE_ANG[(i + 7) % 12]);
        send_angles(17'h1FFFF, 17'h0FFFF, 17'h10000);
        send_angles(17'h0, 17'h0, 17'h0);
        // phases of idling
        in_idle_pct = 0;  out_idle_pct = 0;  send_random(80);
        in_idle_pct = 45; out_idle_pct = 0;  send_random(80);
        in_idle_pct = 0;  out_idle_pct = 45; send_random(80);
        in_idle_pct = 18; out_idle_pct = 18; send_random(80);
        // long output hold-off while the input keeps offering
        in_idle_pct = 0;  out_idle_pct = 0;
        hold_off = 200;
        send_random(80);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
